/* rtl/lbnc_pkg.sv */
// shared types, constants and index helpers for the bloom negative check
package lbnc_pkg;

    localparam int NUM_VARIANTS_DEF = 16;
    localparam int WORDS_PER_BLOOM  = 32;
    localparam int WORD_IDX_W       = 5;
    localparam int WORD_W           = 64;
    localparam int BIT_IDX_W        = 6;
    localparam int IDX_W            = 11;
    localparam int HASH_W           = 48;
    localparam int SLOT_W           = 4;
    localparam int COUNT_W          = 5;
    localparam int ACTION_W         = 2;
    localparam int BLOOM_BYTES      = 256;
    localparam int BITS_PER_ADD     = 3;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int IN_DATA_W        = 128;
    localparam int OUT_DATA_W       = 8;

    // action codes on the input tuser
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BLOCK = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_BLOCK = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                           kind;
        logic [SLOT_W-1:0]                   slot;
        logic [BITS_PER_ADD-1:0][IDX_W-1:0]  idx;
        logic [WORD_IDX_W-1:0]               word_index;
        logic [WORD_W-1:0]                   block_word;
        logic                                last;
    } cmd_t;

    // bloom byte 255 - idx/8 lives in word byte_pos/8
    function automatic logic [WORD_IDX_W-1:0] bloom_word(input logic [IDX_W-1:0] idx);
        logic [7:0] byte_pos;
        byte_pos = 8'(BLOOM_BYTES - 1) - idx[IDX_W-1:3];
        return byte_pos[7:3];
    endfunction

    // bit position inside that word: byte lane times eight plus idx mod 8
    function automatic logic [BIT_IDX_W-1:0] bloom_bit(input logic [IDX_W-1:0] idx);
        logic [7:0] byte_pos;
        byte_pos = 8'(BLOOM_BYTES - 1) - idx[IDX_W-1:3];
        return {byte_pos[2:0], idx[2:0]};
    endfunction

endpackage

/* rtl/lbnc_front.sv */
// input decode: drops unused items, turns hash prefixes into bloom indices
module lbnc_front #(
    parameter int NUM_VARIANTS = lbnc_pkg::NUM_VARIANTS_DEF
) (
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lbnc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic [lbnc_pkg::ACTION_W-1:0]        s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output lbnc_pkg::cmd_t                       cmd
);

    logic [lbnc_pkg::SLOT_W-1:0]  variant;
    logic [lbnc_pkg::HASH_W-1:0]  hash_prefix;
    logic                         slot_ok;
    logic                         keep;

    assign variant     = s_axis_tdata[3:0];
    assign hash_prefix = s_axis_tdata[51:4];
    assign slot_ok     = 9'(variant) < 9'(NUM_VARIANTS);

    always_comb
    begin
        keep     = 1'b0;
        cmd.kind = lbnc_pkg::CMD_BLOCK;
        unique case (s_axis_tuser)
            lbnc_pkg::ACT_CLEAR:
            begin
                keep     = slot_ok;
                cmd.kind = lbnc_pkg::CMD_CLEAR;
            end
            lbnc_pkg::ACT_ADD:
            begin
                keep     = slot_ok;
                cmd.kind = lbnc_pkg::CMD_ADD;
            end
            lbnc_pkg::ACT_BLOCK:
            begin
                keep     = 1'b1;
                cmd.kind = lbnc_pkg::CMD_BLOCK;
            end
            default:
            begin
                keep     = 1'b0;
                cmd.kind = lbnc_pkg::CMD_BLOCK;
            end
        endcase
    end

    // byte zero of the hash sits in the top bits, first pair first
    assign cmd.slot       = variant;
    assign cmd.idx[0]     = hash_prefix[42:32];
    assign cmd.idx[1]     = hash_prefix[26:16];
    assign cmd.idx[2]     = hash_prefix[10:0];
    assign cmd.word_index = s_axis_tdata[56:52];
    assign cmd.block_word = s_axis_tdata[120:57];
    assign cmd.last       = s_axis_tlast;

    // dropped items are taken at the same pace as kept ones
    assign s_axis_tready = cmd_ready;
    assign cmd_valid     = s_axis_tvalid && keep;

endmodule

/* rtl/lbnc_queue.sv */
// short command queue between decode and execution
module lbnc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lbnc_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output lbnc_pkg::cmd_t  out_cmd
);

    localparam logic [lbnc_pkg::QPTR_W-1:0] LAST_PTR = lbnc_pkg::QPTR_W'(lbnc_pkg::QUEUE_DEPTH - 1);
    localparam int CNT_W = lbnc_pkg::QPTR_W + 1;

    lbnc_pkg::cmd_t                  entry_reg [lbnc_pkg::QUEUE_DEPTH];
    logic [lbnc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lbnc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            push, pop;

    assign in_ready  = count_reg != CNT_W'(lbnc_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

/* rtl/lbnc_back.sv */
// execution: variant store memory, clear and add sequencing, per-variant check sweep
module lbnc_back #(
    parameter int NUM_VARIANTS = lbnc_pkg::NUM_VARIANTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  lbnc_pkg::cmd_t                      cmd,
    input  logic [lbnc_pkg::COUNT_W-1:0]        variant_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                negative,
    output logic                                incomplete
);

    localparam int ADDR_W = $clog2(NUM_VARIANTS * lbnc_pkg::WORDS_PER_BLOOM);
    localparam int VIDX_W = (NUM_VARIANTS > 1) ? $clog2(NUM_VARIANTS) : 1;
    localparam int CMP_W  = (VIDX_W > lbnc_pkg::COUNT_W) ? VIDX_W : lbnc_pkg::COUNT_W;
    localparam logic [VIDX_W-1:0] LAST_V = VIDX_W'(NUM_VARIANTS - 1);
    localparam logic [lbnc_pkg::WORD_IDX_W-1:0] LAST_W =
        lbnc_pkg::WORD_IDX_W'(lbnc_pkg::WORDS_PER_BLOOM - 1);
    localparam logic [1:0] LAST_SEL = 2'(lbnc_pkg::BITS_PER_ADD - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_ADD_RD = 5'b00100,
        ST_ADD_WR = 5'b01000,
        ST_BLOCK  = 5'b10000
    } state_t;

    logic [lbnc_pkg::WORD_W-1:0]  mem [NUM_VARIANTS * lbnc_pkg::WORDS_PER_BLOOM];

    state_t                                  state_reg, state_next;
    lbnc_pkg::cmd_t                          cmd_reg, cmd_next;
    logic [lbnc_pkg::WORD_IDX_W-1:0]         wcnt_reg, wcnt_next;
    logic [1:0]                              sel_reg, sel_next;
    logic [VIDX_W-1:0]                       vcnt_reg, vcnt_next;
    logic                                    issue_reg, issue_next;
    logic                                    cmp_valid_reg, cmp_valid_next;
    logic [VIDX_W-1:0]                       cmp_v_reg, cmp_v_next;
    logic [NUM_VARIANTS-1:0]                 failed_reg, failed_next;
    logic [lbnc_pkg::WORDS_PER_BLOOM-1:0]    seen_reg, seen_next;
    logic                                    all_fail_reg, all_fail_next;
    logic                                    out_valid_reg, out_valid_next;
    logic                                    negative_reg, negative_next;
    logic                                    incomplete_reg, incomplete_next;
    logic [lbnc_pkg::WORD_W-1:0]             rdata_reg;

    logic [ADDR_W-1:0]                       rd_addr, wr_addr;
    logic [ADDR_W-1:0]                       slot_base;
    logic                                    mem_we;
    logic [lbnc_pkg::WORD_W-1:0]             wdata;
    logic [lbnc_pkg::IDX_W-1:0]              idx_sel;
    logic                                    pop;
    logic                                    hit;
    logic                                    pass_now;

    assign slot_base = ADDR_W'(cmd_reg.slot) << lbnc_pkg::WORD_IDX_W;
    assign idx_sel   = cmd_reg.idx[sel_reg];
    assign hit       = |(rdata_reg & ~cmd_reg.block_word);
    // a counted variant that still passes after this word breaks the all-failed run
    assign pass_now  = (CMP_W'(cmp_v_reg) < CMP_W'(variant_count))
                       && !(failed_reg[cmp_v_reg] || hit);

    // a final block word waits until the output register is free
    assign cmd_ready = (state_reg == ST_IDLE)
                       && (!(cmd.kind == lbnc_pkg::CMD_BLOCK && cmd.last)
                           || !out_valid_reg || out_ready);
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        wcnt_next       = wcnt_reg;
        sel_next        = sel_reg;
        vcnt_next       = vcnt_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_v_next      = vcnt_reg;
        failed_next     = failed_reg;
        seen_next       = seen_reg;
        all_fail_next   = all_fail_reg;
        out_valid_next  = out_valid_reg;
        negative_next   = negative_reg;
        incomplete_next = incomplete_reg;
        rd_addr         = slot_base + ADDR_W'(lbnc_pkg::bloom_word(idx_sel));
        wr_addr         = slot_base + ADDR_W'(lbnc_pkg::bloom_word(idx_sel));
        mem_we          = 1'b0;
        wdata           = rdata_reg | (64'd1 << lbnc_pkg::bloom_bit(idx_sel));

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cmd_next = cmd;
                    unique case (cmd.kind)
                        lbnc_pkg::CMD_CLEAR:
                        begin
                            wcnt_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        lbnc_pkg::CMD_ADD:
                        begin
                            sel_next   = '0;
                            state_next = ST_ADD_RD;
                        end
                        lbnc_pkg::CMD_BLOCK:
                        begin
                            vcnt_next     = '0;
                            issue_next    = 1'b1;
                            all_fail_next = 1'b1;
                            seen_next     = seen_reg
                                            | (lbnc_pkg::WORDS_PER_BLOOM'(1) << cmd.word_index);
                            state_next    = ST_BLOCK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                wr_addr   = slot_base + ADDR_W'(wcnt_reg);
                wdata     = '0;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == LAST_W)
                    state_next = ST_IDLE;
            end
            ST_ADD_RD:
            begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                mem_we = 1'b1;
                if (sel_reg == LAST_SEL)
                    state_next = ST_IDLE;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_ADD_RD;
                end
            end
            ST_BLOCK:
            begin
                // read stage: one variant word per cycle
                rd_addr = (ADDR_W'(vcnt_reg) << lbnc_pkg::WORD_IDX_W)
                          + ADDR_W'(cmd_reg.word_index);
                if (issue_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_v_next     = vcnt_reg;
                    vcnt_next      = vcnt_reg + 1'b1;
                    if (vcnt_reg == LAST_V)
                        issue_next = 1'b0;
                end
                // compare stage, in the cycle after the read
                if (cmp_valid_reg)
                begin
                    if (hit)
                        failed_next[cmp_v_reg] = 1'b1;
                    if (pass_now)
                        all_fail_next = 1'b0;
                    if (cmp_v_reg == LAST_V)
                    begin
                        state_next = ST_IDLE;
                        if (cmd_reg.last)
                        begin
                            out_valid_next  = 1'b1;
                            negative_next   = (variant_count != '0) && (&seen_reg)
                                              && all_fail_reg && !pass_now;
                            incomplete_next = !(&seen_reg);
                            failed_next     = '0;
                            seen_next       = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wcnt_reg      <= '0;
            sel_reg       <= '0;
            vcnt_reg      <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_v_reg     <= '0;
            failed_reg    <= '0;
            seen_reg      <= '0;
            all_fail_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wcnt_reg      <= wcnt_next;
            sel_reg       <= sel_next;
            vcnt_reg      <= vcnt_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_v_reg     <= cmp_v_next;
            failed_reg    <= failed_next;
            seen_reg      <= seen_next;
            all_fail_reg  <= all_fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        negative_reg   <= negative_next;
        incomplete_reg <= incomplete_next;
    end

    // variant store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wdata;
        rdata_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign negative   = negative_reg;
    assign incomplete = incomplete_reg;

    a_result_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_BLOCK))
        else $error("result raised outside a check sweep");

    a_marks_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (seen_reg == '0) && (failed_reg == '0))
        else $error("seen words or failed marks kept after a final word");

    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(negative_reg && incomplete_reg))
        else $error("negative reported on an incomplete block");

    a_compare_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> state_reg == ST_BLOCK)
        else $error("compare stage active outside a check sweep");

endmodule

/* rtl/log_bloom_negative_check_unit.sv */
// top level of the log bloom negative check: config register, decode, queue, execution
// a final block word gives its result once every variant's word has been read and compared
// a block word holds the store for its whole sweep (one read a variant); no new word is taken meanwhile
// a clear writes the slot's 32 store words (one written a cycle), an add does three read-modify-writes
// the input queues up to two kept words ahead while the store is busy
// reset clears control, flags and variant_count; the variant store stays undefined until written
module log_bloom_negative_check_unit #(
    parameter int NUM_VARIANTS = lbnc_pkg::NUM_VARIANTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input words
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // variant[3:0], hash_prefix[51:4], word_index[56:52], block_word[120:57], zero pad
    input  logic [lbnc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // action[1:0]
    input  logic [lbnc_pkg::ACTION_W-1:0]        s_axis_tuser,
    // last_word
    input  logic                                 s_axis_tlast,
    // result words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // negative[0], incomplete[1], zero pad
    output logic [lbnc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // variant_count register write
    input  logic                                 cfg_we,
    input  logic [lbnc_pkg::COUNT_W-1:0]         cfg_wdata
);

    logic [lbnc_pkg::COUNT_W-1:0]  variant_count_reg;

    logic            front_valid;
    logic            front_ready;
    lbnc_pkg::cmd_t  front_cmd;
    logic            back_valid;
    logic            back_ready;
    lbnc_pkg::cmd_t  back_cmd;
    logic            negative;
    logic            incomplete;

    // counts above NUM_VARIANTS act as NUM_VARIANTS in the check sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            variant_count_reg <= '0;
        else if (cfg_we)
            variant_count_reg <= cfg_wdata;
    end

    // decode: drops unused actions and clears or adds to out-of-range slots, precomputes bloom indices
    lbnc_front #(
        .NUM_VARIANTS (NUM_VARIANTS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    // decouples decode from the store so each side stalls on its own
    lbnc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    // store updates and the per-variant check sweep, with the result register
    lbnc_back #(
        .NUM_VARIANTS (NUM_VARIANTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (back_valid),
        .cmd_ready     (back_ready),
        .cmd           (back_cmd),
        .variant_count (variant_count_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .negative      (negative),
        .incomplete    (incomplete)
    );

    assign m_axis_tdata = {6'd0, incomplete, negative};

endmodule
